@@ sv/gia_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gia_pkg
// Shared types and constants for the generational id allocator.
// ----------------------------------------------------------------------------
package gia_pkg;

    // table geometry, fixed by the handle format
    localparam int MAX_SLOTS = 1024;
    localparam int IDX_W     = 10;
    localparam int VER_W     = 8;
    localparam int CNT_W     = 11;
    localparam int KIND_W    = 3;

    localparam logic [CNT_W-1:0] MAX_SLOTS_CNT = CNT_W'(MAX_SLOTS);

    // request codes
    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC     = 3'd0,
        KIND_FREE_HDL  = 3'd1,
        KIND_FREE_IDX  = 3'd2,
        KIND_CHECK_HDL = 3'd3,
        KIND_CHECK_IDX = 3'd4,
        KIND_CLEAR     = 3'd5
    } kind_t;

    // commands from the control logic to the free list
    typedef struct packed {
        logic             rd;
        logic             pop;
        logic             push;
        logic             clear;
        logic [IDX_W-1:0] push_index;
    } fl_cmd_t;

    // free list status back to the control logic
    typedef struct packed {
        logic [IDX_W-1:0] head_index;
        logic [CNT_W-1:0] count;
    } fl_stat_t;

    // circular pointer advance
    function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
        logic [IDX_W-1:0] r;
        if (p == IDX_W'(MAX_SLOTS - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

endpackage

@@ sv/gia_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gia_ram
// Simple dual-port synchronous RAM, one write and one read port, registered
// read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module gia_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 10
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ sv/gia_free_list.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gia_free_list
// FIFO of freed slot indices: circular buffer in a RAM with head, tail and
// fill count registers.
// ----------------------------------------------------------------------------
module gia_free_list (
    input  logic              aclk,
    input  logic              aresetn,
    input  gia_pkg::fl_cmd_t  cmd,
    output gia_pkg::fl_stat_t stat
);
    import gia_pkg::*;

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] head_data;

    // index storage
    gia_ram #(
        .DATA_W(IDX_W),
        .ADDR_W(IDX_W)
    ) u_fifo_ram (
        .aclk  (aclk),
        .we    (cmd.push),
        .waddr (tail_reg),
        .wdata (cmd.push_index),
        .re    (cmd.rd),
        .raddr (head_reg),
        .rdata (head_data)
    );

    // pointer and count update
    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (cmd.clear) begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end else begin
            if (cmd.pop) begin
                head_next = ptr_inc(head_reg);
            end
            if (cmd.push) begin
                tail_next = ptr_inc(tail_reg);
            end
            count_next = count_reg + CNT_W'(cmd.push) - CNT_W'(cmd.pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign stat.head_index = head_data;
    assign stat.count      = count_reg;

    // the list never holds more than the table
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_SLOTS_CNT)
        else $error("free list count beyond table size");

    // pop and push never come from the same request
    a_no_pop_push: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.pop && cmd.push))
        else $error("free list pop and push together");

    // a pop only happens on a non-empty list
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> count_reg != '0)
        else $error("free list pop while empty");

endmodule

@@ sv/generational_id_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generational_id_allocator
// Allocates and frees generational handles (slot index plus 8-bit version),
// with a FIFO free list and a per-slot version memory.
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_valid / s_ready  | kind, slot_index, slot_version
//   m_      | out       | m_valid / m_ready  | ok, out_index, out_version,
//           |           |                    | live_count, high_water
//
// Each request passes through these steps in order: accept plus free list head
// read, version memory read, then the version write-back and result load. A
// request is accepted while the previous result still waits in the output
// register; a stalled result holds the request in its final step. Reset is
// synchronous and active low; no memory clearing pass is needed, slots are
// rewritten as they are opened.
// ----------------------------------------------------------------------------
module generational_id_allocator (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [gia_pkg::KIND_W-1:0] s_kind,
    input  logic [gia_pkg::IDX_W-1:0] s_slot_index,
    input  logic [gia_pkg::VER_W-1:0] s_slot_version,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_ok,
    output logic [gia_pkg::IDX_W-1:0] m_out_index,
    output logic [gia_pkg::VER_W-1:0] m_out_version,
    output logic [gia_pkg::CNT_W-1:0] m_live_count,
    output logic [gia_pkg::CNT_W-1:0] m_high_water
);
    import gia_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EXEC
    } state_t;

    state_t           state_reg, state_next;
    kind_t            kind_reg, kind_next;
    logic [IDX_W-1:0] index_reg, index_next;
    logic [VER_W-1:0] version_reg, version_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0] opened_reg, opened_next;

    logic             m_valid_reg, m_valid_next;
    logic             m_ok_reg, m_ok_next;
    logic [IDX_W-1:0] m_index_reg, m_index_next;
    logic [VER_W-1:0] m_version_reg, m_version_next;
    logic [CNT_W-1:0] m_live_reg, m_live_next;
    logic [CNT_W-1:0] m_high_reg, m_high_next;

    fl_cmd_t          fl_cmd;
    fl_stat_t         fl_stat;

    logic             ver_we;
    logic [VER_W-1:0] ver_wdata;
    logic             ver_re;
    logic [VER_W-1:0] ver_rdata;

    logic             accept;
    logic             out_free;
    logic             exec_fire;
    logic             from_list;
    logic             fresh;
    logic             in_range;
    logic             live;
    logic             match;
    logic [VER_W-1:0] ver_inc;
    logic [CNT_W-1:0] count_after;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign exec_fire = (state_reg == ST_EXEC) && out_free;

    // per-slot version memory
    gia_ram #(
        .DATA_W(VER_W),
        .ADDR_W(IDX_W)
    ) u_ver_ram (
        .aclk  (aclk),
        .we    (ver_we),
        .waddr (slot_reg),
        .wdata (ver_wdata),
        .re    (ver_re),
        .raddr (slot_next),
        .rdata (ver_rdata)
    );

    // free list of released slots
    gia_free_list u_free_list (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (fl_cmd),
        .stat    (fl_stat)
    );

    // slot state decode, valid in the final step
    assign from_list = (fl_stat.count != '0);
    assign fresh     = !from_list && (opened_reg < MAX_SLOTS_CNT);
    assign in_range  = (CNT_W'(index_reg) < opened_reg);
    assign live      = in_range && ver_rdata[0];
    assign match     = live && (ver_rdata == version_reg);
    assign ver_inc   = (kind_reg == KIND_ALLOC && fresh) ? VER_W'(1) : ver_rdata + 1'b1;

    // request sequencing and result formation
    always_comb begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        index_next     = index_reg;
        version_next   = version_reg;
        slot_next      = slot_reg;
        opened_next    = opened_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_ok_next      = m_ok_reg;
        m_index_next   = m_index_reg;
        m_version_next = m_version_reg;
        m_live_next    = m_live_reg;
        m_high_next    = m_high_reg;
        fl_cmd         = '0;
        ver_we         = 1'b0;
        ver_wdata      = ver_inc;
        ver_re         = 1'b0;
        count_after    = fl_stat.count;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    kind_next    = kind_t'(s_kind);
                    index_next   = s_slot_index;
                    version_next = s_slot_version;
                    fl_cmd.rd    = 1'b1;
                    state_next   = ST_FETCH;
                end
            end
            ST_FETCH: begin
                // pick slot: list head or fresh slot (alloc), else request index
                if (kind_reg == KIND_ALLOC) begin
                    if (from_list) begin
                        slot_next = fl_stat.head_index;
                    end else begin
                        slot_next = opened_reg[IDX_W-1:0];
                    end
                end else begin
                    slot_next = index_reg;
                end
                ver_re     = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (out_free) begin
                    m_ok_next      = 1'b0;
                    m_index_next   = '0;
                    m_version_next = '0;
                    case (kind_reg)
                        KIND_ALLOC: begin
                            if (from_list || fresh) begin
                                ver_we         = 1'b1;
                                fl_cmd.pop     = from_list;
                                m_ok_next      = 1'b1;
                                m_index_next   = slot_reg;
                                m_version_next = ver_inc;
                                if (fresh) begin
                                    opened_next = opened_reg + 1'b1;
                                end
                            end
                        end
                        KIND_FREE_HDL, KIND_FREE_IDX: begin
                            if ((kind_reg == KIND_FREE_HDL) ? match : live) begin
                                ver_we            = 1'b1;
                                fl_cmd.push       = 1'b1;
                                fl_cmd.push_index = slot_reg;
                                m_ok_next         = 1'b1;
                            end
                        end
                        KIND_CHECK_HDL: begin
                            m_ok_next = match;
                        end
                        KIND_CHECK_IDX: begin
                            m_ok_next = live;
                        end
                        KIND_CLEAR: begin
                            fl_cmd.clear = 1'b1;
                            opened_next  = '0;
                            m_ok_next    = 1'b1;
                        end
                        default: begin
                            m_ok_next = 1'b0;
                        end
                    endcase
                    // counts after this request
                    if (fl_cmd.clear) begin
                        count_after = '0;
                    end else begin
                        count_after = fl_stat.count + CNT_W'(fl_cmd.push)
                                      - CNT_W'(fl_cmd.pop);
                    end
                    m_live_next  = opened_next - count_after;
                    m_high_next  = opened_next;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            opened_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            opened_reg  <= opened_next;
            m_valid_reg <= m_valid_next;
        end
        kind_reg      <= kind_next;
        index_reg     <= index_next;
        version_reg   <= version_next;
        slot_reg      <= slot_next;
        m_ok_reg      <= m_ok_next;
        m_index_reg   <= m_index_next;
        m_version_reg <= m_version_next;
        m_live_reg    <= m_live_next;
        m_high_reg    <= m_high_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_ok          = m_ok_reg;
    assign m_out_index   = m_index_reg;
    assign m_out_version = m_version_reg;
    assign m_live_count  = m_live_reg;
    assign m_high_water  = m_high_reg;

    // opened slots never exceed the table
    a_opened_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        opened_reg <= MAX_SLOTS_CNT)
        else $error("high-water mark beyond table size");

    // every queued slot was opened before
    a_free_le_opened: assert property (@(posedge aclk) disable iff (!aresetn)
        fl_stat.count <= opened_reg)
        else $error("free list larger than opened slots");

    // a granted handle always carries an odd version
    a_alloc_odd: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec_fire && kind_reg == KIND_ALLOC && ver_we) |-> ver_inc[0])
        else $error("allocated handle with even version");

    // the final step is only reached through the version read
    a_exec_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC) |->
            ($past(state_reg) == ST_FETCH || $past(state_reg) == ST_EXEC))
        else $error("final step entered without version read");

endmodule
